// ===== design/vzc_pkg.sv =====
// Shared types and constants for the varint / zigzag codec.
package vzc_pkg;

    // Item codes: the action of an input item and the kind of a result share one encoding.
    localparam logic K_ENCODE = 1'b0;
    localparam logic K_DECODE = 1'b1;

    // Base-128 group size and byte limits.
    localparam int unsigned GROUP_W   = 7;
    localparam logic [3:0]  LIM_NARROW = 4'd5;
    localparam logic [3:0]  LIM_WIDE   = 4'd10;
    localparam logic [3:0]  MAX_CONT   = 4'd9;

    // Default depth of the front-to-back queue.
    localparam int unsigned QDEPTH = 2;

    // Classified item as handed from front to back.
    typedef struct packed {
        logic        dec;   // K_DECODE for a decode byte
        logic        wide;
        logic        zz;
        logic [63:0] data;  // mapped value to encode, or the byte to decode
    } t_item;

endpackage

// ===== design/vzc_front.sv =====
// Front end: takes input transfers, applies zigzag and width masking, classifies.
module vzc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_action,
    input  logic           i_wide,
    input  logic           i_signed_zigzag,
    input  logic [63:0]    i_value,
    input  logic [7:0]     i_in_byte,
    output logic           o_push,
    input  logic           i_push_ready,
    output vzc_pkg::t_item o_item
);

    logic           r_valid;
    vzc_pkg::t_item r_item;
    vzc_pkg::t_item n_item;
    logic [31:0]    v32;

    assign v32 = i_value[31:0];

    always_comb begin
        n_item.dec  = i_action;
        n_item.wide = i_wide;
        n_item.zz   = i_signed_zigzag;
        if (i_action == vzc_pkg::K_DECODE) begin
            n_item.data = {56'd0, i_in_byte};
        end else if (i_wide) begin
            n_item.data = i_signed_zigzag ? ({i_value[62:0], 1'b0} ^ {64{i_value[63]}})
                                          : i_value;
        end else begin
            n_item.data = i_signed_zigzag ? {32'd0, {v32[30:0], 1'b0} ^ {32{v32[31]}}}
                                          : {32'd0, v32};
        end
    end

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== design/vzc_queue.sv =====
// Small queue that decouples the front end from the back end.
module vzc_queue #(
    parameter int unsigned DEPTH = vzc_pkg::QDEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_push_ready,
    input  vzc_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_pop,
    output vzc_pkg::t_item o_item
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    vzc_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_item       = r_mem[r_rptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// ===== design/vzc_back.sv =====
// Back end: byte serialiser for encodes, accumulator for decodes, output register.
module vzc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  vzc_pkg::t_item i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_kind,
    output logic [7:0]     o_out_byte,
    output logic           o_last,
    output logic [63:0]    o_decoded_value
);

    // serialiser
    logic        r_busy;
    logic [63:0] r_sh;
    logic [3:0]  r_n;
    // decoder state
    logic [63:0] r_acc;
    logic [3:0]  r_cnt;
    // output register
    logic        r_ovalid;
    logic        r_kind;
    logic [7:0]  r_out_byte;
    logic        r_last;
    logic [63:0] r_dec;

    logic        n_busy;
    logic [63:0] n_sh;
    logic [3:0]  n_n;
    logic [63:0] n_acc;
    logic [3:0]  n_cnt;
    logic        n_ovalid;
    logic        n_kind;
    logic [7:0]  n_out_byte;
    logic        n_last;
    logic [63:0] n_dec;

    logic        out_adv;
    logic [63:0] cur;
    logic [3:0]  cur_n;
    logic        more;
    logic [3:0]  cnt;
    logic [5:0]  sh_amt;
    logic [63:0] acc;
    logic [3:0]  limit;
    logic        ends;
    logic [31:0] a32;
    logic [31:0] z32;
    logic [63:0] dec_val;

    assign out_adv = !r_ovalid || i_ready;
    assign o_pop   = i_head_valid && !r_busy && out_adv;

    // encode step: current group source is either the held value or a fresh head
    assign cur   = r_busy ? r_sh : i_head.data;
    assign cur_n = r_busy ? r_n : 4'd0;
    assign more  = (cur[63:7] != '0) && (cur_n < vzc_pkg::MAX_CONT);

    // decode step
    assign cnt    = (r_cnt > vzc_pkg::MAX_CONT) ? vzc_pkg::MAX_CONT : r_cnt;
    assign sh_amt = 6'({2'd0, cnt} * 6'd7);
    assign acc    = r_acc | ({57'd0, i_head.data[6:0]} << sh_amt);
    assign limit  = i_head.wide ? vzc_pkg::LIM_WIDE : vzc_pkg::LIM_NARROW;
    assign ends   = !i_head.data[7] || (4'(cnt + 4'd1) >= limit);
    assign a32    = acc[31:0];
    assign z32    = {1'b0, a32[31:1]} ^ {32{a32[0]}};

    always_comb begin
        if (i_head.wide) begin
            dec_val = i_head.zz ? ({1'b0, acc[63:1]} ^ {64{acc[0]}}) : acc;
        end else begin
            dec_val = i_head.zz ? {{32{z32[31]}}, z32} : {32'd0, a32};
        end
    end

    always_comb begin
        n_busy     = r_busy;
        n_sh       = r_sh;
        n_n        = r_n;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_ovalid   = r_ovalid && !i_ready;
        n_kind     = r_kind;
        n_out_byte = r_out_byte;
        n_last     = r_last;
        n_dec      = r_dec;
        if (out_adv) begin
            if (r_busy || (i_head_valid && i_head.dec == vzc_pkg::K_ENCODE)) begin
                n_ovalid   = 1'b1;
                n_kind     = vzc_pkg::K_ENCODE;
                n_out_byte = more ? {1'b1, cur[6:0]} : cur[7:0];
                n_last     = !more;
                n_dec      = '0;
                n_busy     = more;
                n_sh       = {7'd0, cur[63:7]};
                n_n        = cur_n + 4'd1;
            end else if (i_head_valid) begin
                if (ends) begin
                    n_ovalid   = 1'b1;
                    n_kind     = vzc_pkg::K_DECODE;
                    n_out_byte = '0;
                    n_last     = 1'b0;
                    n_dec      = dec_val;
                    n_acc      = '0;
                    n_cnt      = '0;
                end else begin
                    n_acc = acc;
                    n_cnt = cnt + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_n      <= '0;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_n      <= n_n;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_sh       <= n_sh;
        r_kind     <= n_kind;
        r_out_byte <= n_out_byte;
        r_last     <= n_last;
        r_dec      <= n_dec;
    end

    assign o_valid         = r_ovalid;
    assign o_kind          = r_kind;
    assign o_out_byte      = r_out_byte;
    assign o_last          = r_last;
    assign o_decoded_value = r_dec;

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_n != 4'd0) && (r_n <= vzc_pkg::MAX_CONT))
        else $error("serialiser byte index out of range");

    a_dec_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= vzc_pkg::MAX_CONT)
        else $error("decode byte count out of range");

    a_cont_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_kind == vzc_pkg::K_ENCODE) |-> (r_out_byte[7] == !r_last))
        else $error("continuation bit disagrees with last flag");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_pop)
        else $error("queue popped while serialising");

    a_dec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_kind == vzc_pkg::K_DECODE) |-> (r_out_byte == 8'd0) && !r_last)
        else $error("decode result carries encode fields");

endmodule

// ===== design/varint_zigzag_codec.sv =====
// Top level of the base-128 varint codec with optional zigzag mapping.
// Varint codec, 32- or 64-bit, seven bits per byte, lowest group first, bit 7 set on every
// byte but the last. An encode transfer (i_action = 0) yields 1..5 (narrow) or 1..10 (wide)
// byte results, the final one with o_last high. A decode transfer (i_action = 1) hands in
// one byte; a value result appears only on the byte with bit 7 clear or on the 5th / 10th
// byte, and excess high bits are dropped. Width and zigzag of a decoded value come from the
// byte that completes it. Encodes do not disturb a decode in progress.
// Timing: the front end takes one transfer per cycle while the queue has room. The back
// end's byte serialiser emits one byte per cycle while i_ready does not hold the output,
// and it takes no new item from the queue until an encode's last byte is out. With an idle
// output, the first result is held in the front register, then the queue, then the output
// register, which drives o_valid. The output register lets new input be taken while a
// result waits for i_ready.
module varint_zigzag_codec #(
    parameter int unsigned QUEUE_DEPTH = vzc_pkg::QDEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic        i_wide,
    input  logic        i_signed_zigzag,
    input  logic [63:0] i_value,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic [63:0] o_decoded_value
);

    logic           push;
    logic           push_ready;
    vzc_pkg::t_item front_item;
    logic           head_valid;
    logic           pop;
    vzc_pkg::t_item head_item;

    // front: register the transfer, zigzag-map encodes, mask narrow values
    vzc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_wide          (i_wide),
        .i_signed_zigzag (i_signed_zigzag),
        .i_value         (i_value),
        .i_in_byte       (i_in_byte),
        .o_push          (push),
        .i_push_ready    (push_ready),
        .o_item          (front_item)
    );

    // queue: lets the front keep accepting while the serialiser runs
    vzc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_item       (front_item),
        .o_valid      (head_valid),
        .i_pop        (pop),
        .o_item       (head_item)
    );

    // back: byte serialiser and decode accumulator, registered output
    vzc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (head_valid),
        .i_head          (head_item),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_out_byte      (o_out_byte),
        .o_last          (o_last),
        .o_decoded_value (o_decoded_value)
    );

endmodule
